// ===== rtl/mcmc_pkg.sv =====
// Shared constants and types for the matrix-chain minimum cost unit.
package mcmc_pkg;

   localparam int MAX_DIMS  = 32;
   localparam int DIM_BITS  = 16;
   localparam int IDX_BITS  = $clog2(MAX_DIMS);
   localparam int CNT_BITS  = $clog2(MAX_DIMS + 1);
   localparam int COST_BITS = 53;
   localparam int PAIR_BITS = 2 * DIM_BITS;
   localparam int PROD_BITS = 3 * DIM_BITS;
   localparam int COST_ADDR_BITS = 2 * IDX_BITS;

   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = ((COST_BITS + 7) / 8) * 8;

   localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_I,
      S_RD_J,
      S_MUL,
      S_RUN,
      S_DRAIN,
      S_DONE
   } state_type;

   // Saturating cost addition; both operands are at most COST_MAX.
   function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                     input logic [COST_BITS-1:0] b);
      logic [COST_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
   endfunction

endpackage

// ===== rtl/matrix_chain_min_cost_unit.sv =====
// Matrix-chain minimum cost: loads a dimension chain, runs the interval DP, reports the cost.
// Dimensions that do not close a chain are accepted back to back. After the closing
// transaction each interval i..j takes two dimension reads, one split a cycle through the
// shared multiply and add/compare pipeline, then a drain of that pipeline. A chain of two or
// fewer dimensions skips the DP and goes straight to the result. The input is not ready
// while a chain is processed. Reset is synchronous, active high; tables are not cleared.
module matrix_chain_min_cost_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mcmc_pkg::REQ_DATA_BITS-1:0] req_tdata,   // [15:0] dimension
   input  logic                               req_tlast,   // last
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mcmc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,   // [52:0] min_cost, rest zero
   output logic                               rsp_tuser    // dropped
);
   import mcmc_pkg::*;

   state_type                 state_ff;
   logic [CNT_BITS-1:0]       count_ff;
   logic                      drop_ff;
   logic                      res_drop_ff;
   logic [IDX_BITS-1:0]       i_ff;
   logic [IDX_BITS-1:0]       j_ff;
   logic [IDX_BITS-1:0]       k_ff;
   logic [IDX_BITS-1:0]       last_idx_ff;

   logic [DIM_BITS-1:0]       dim_mem [0:MAX_DIMS-1];
   logic [DIM_BITS-1:0]       dim_rd_ff;
   logic [COST_BITS-1:0]      cost_mem [0:(1 << COST_ADDR_BITS)-1];
   logic [COST_BITS-1:0]      cost_a_ff;
   logic [COST_BITS-1:0]      cost_b_ff;

   logic [DIM_BITS-1:0]       pi_ff;
   logic [PAIR_BITS-1:0]      pij_ff;
   logic [PROD_BITS-1:0]      prod_ff;
   logic [COST_BITS-1:0]      sum_ff;
   logic [COST_BITS-1:0]      best_ff;
   logic                      s1_valid_ff;
   logic                      s1_first_ff;
   logic                      s1_zero_b_ff;
   logic                      s2_valid_ff;
   logic                      s2_first_ff;

   logic                      rsp_valid_ff;
   logic [COST_BITS-1:0]      rsp_cost_ff;
   logic                      rsp_drop_ff;

   logic                      req_accept;
   logic                      room;
   logic [CNT_BITS-1:0]       count_next;
   logic [CNT_BITS-1:0]       last_pos;
   logic                      drop_next;
   logic                      issue;
   logic                      pipe_busy;
   logic                      rsp_free;
   logic                      cost_we;
   logic [IDX_BITS-1:0]       k_plus;
   logic [IDX_BITS-1:0]       dim_raddr;
   logic [COST_ADDR_BITS-1:0] cost_addr_a;
   logic [COST_ADDR_BITS-1:0] cost_addr_b;
   logic [COST_BITS-1:0]      q;

   assign req_tready  = (state_ff == S_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign room        = (count_ff < CNT_BITS'(MAX_DIMS));
   assign count_next  = room ? count_ff + CNT_BITS'(1) : count_ff;
   assign last_pos    = count_next - CNT_BITS'(1);
   assign drop_next   = drop_ff || !room;
   assign issue       = (state_ff == S_MUL) || (state_ff == S_RUN);
   assign pipe_busy   = s1_valid_ff || s2_valid_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign cost_we     = (state_ff == S_DRAIN) && !pipe_busy;
   assign k_plus      = k_ff + IDX_BITS'(1);
   assign cost_addr_a = {i_ff, k_ff};
   assign cost_addr_b = {k_plus, j_ff};
   // A product of three DIM_BITS values never exceeds the cost width, so no clamp is needed.
   assign q           = sat_add(sum_ff, COST_BITS'(prod_ff));

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = RSP_DATA_BITS'(rsp_cost_ff);
   assign rsp_tuser   = rsp_drop_ff;

   always_comb begin
      unique case (state_ff)
         S_RD_I:  dim_raddr = i_ff - IDX_BITS'(1);
         S_RD_J:  dim_raddr = j_ff;
         default: dim_raddr = k_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_accept && room) begin
         dim_mem[count_ff[IDX_BITS-1:0]] <= req_tdata[DIM_BITS-1:0];
      end
      dim_rd_ff <= dim_mem[dim_raddr];
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[{i_ff, j_ff}] <= best_ff;
      end
      cost_a_ff <= cost_mem[cost_addr_a];
      cost_b_ff <= cost_mem[cost_addr_b];
   end

   // Split pipeline: table and dimension reads, then product and partial sum, then the minimum.
   // Diagonal entries are zero, so reads of cost(i,i) and cost(j,j) are replaced by zero.
   always_ff @(posedge clock) begin
      s1_first_ff  <= (k_ff == i_ff);
      s1_zero_b_ff <= (k_plus == j_ff);
      s2_first_ff  <= s1_first_ff;
      prod_ff      <= pij_ff * dim_rd_ff;
      sum_ff       <= sat_add(s1_first_ff ? '0 : cost_a_ff, s1_zero_b_ff ? '0 : cost_b_ff);
      if (state_ff == S_RD_J) begin
         pi_ff <= dim_rd_ff;
      end
      if (state_ff == S_MUL) begin
         pij_ff <= pi_ff * dim_rd_ff;
      end
      if (req_accept && req_tlast) begin
         best_ff <= '0;
      end else if (s2_valid_ff && (s2_first_ff || (q < best_ff))) begin
         best_ff <= q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         if (rsp_valid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  if (req_tlast) begin
                     count_ff    <= '0;
                     drop_ff     <= 1'b0;
                     res_drop_ff <= drop_next;
                     last_idx_ff <= last_pos[IDX_BITS-1:0];
                     i_ff        <= IDX_BITS'(1);
                     j_ff        <= IDX_BITS'(2);
                     state_ff    <= (count_next > CNT_BITS'(2)) ? S_RD_I : S_DONE;
                  end else begin
                     count_ff <= count_next;
                     drop_ff  <= drop_next;
                  end
               end
            end
            S_RD_I: begin
               k_ff     <= i_ff;
               state_ff <= S_RD_J;
            end
            S_RD_J: begin
               state_ff <= S_MUL;
            end
            S_MUL, S_RUN: begin
               k_ff     <= k_plus;
               state_ff <= (k_plus == j_ff) ? S_DRAIN : S_RUN;
            end
            S_DRAIN: begin
               if (!pipe_busy) begin
                  if ((i_ff == IDX_BITS'(1)) && (j_ff == last_idx_ff)) begin
                     state_ff <= S_DONE;
                  end else if (j_ff == last_idx_ff) begin
                     // Next interval length starts again at the left end of the chain.
                     i_ff     <= IDX_BITS'(1);
                     j_ff     <= j_ff - i_ff + IDX_BITS'(2);
                     state_ff <= S_RD_I;
                  end else begin
                     i_ff     <= i_ff + IDX_BITS'(1);
                     j_ff     <= j_ff + IDX_BITS'(1);
                     state_ff <= S_RD_I;
                  end
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cost_ff  <= best_ff;
                  rsp_drop_ff  <= res_drop_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== dv/tb_matrix_chain_min_cost_unit.sv =====
// Self-checking testbench for the matrix-chain minimum cost unit.
module tb_matrix_chain_min_cost_unit;
   import mcmc_pkg::*;

   typedef struct packed {
      logic [COST_BITS-1:0] min_cost;
      logic                 dropped;
   } chain_result_type;

   typedef enum int {
      STALL_NONE,
      STALL_PATTERN,
      STALL_RANDOM
   } stall_kind_type;

   localparam logic [12:0] STALL_BITS = 13'b1011001110100;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;

   // Shadow copy of the chain being loaded and of the interval cost table.
   logic [DIM_BITS-1:0]  chain_dims [MAX_DIMS];
   logic [COST_BITS-1:0] interval_cost [MAX_DIMS][MAX_DIMS];
   int unsigned          chain_len      = 0;
   logic                 chain_overflow = 1'b0;
   chain_result_type     pending_costs[$];

   int unsigned    errors       = 0;
   int unsigned    dims_sent    = 0;
   int unsigned    chains_sent  = 0;
   int unsigned    results_seen = 0;
   int unsigned    dropped_seen = 0;
   int unsigned    burst_left   = 0;
   int unsigned    gap_max      = 0;
   stall_kind_type stall_mode   = STALL_NONE;

   matrix_chain_min_cost_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [COST_BITS-1:0] cost_sum(input logic [COST_BITS-1:0] a,
                                                      input logic [COST_BITS-1:0] b);
      logic [63:0] total;
      total = 64'(a) + 64'(b);
      return (total > 64'(COST_MAX)) ? COST_MAX : total[COST_BITS-1:0];
   endfunction

   // Interval dynamic program over the first n kept dimensions.
   function automatic logic [COST_BITS-1:0] chain_min_cost(input int unsigned n);
      logic [COST_BITS-1:0] best;
      logic [COST_BITS-1:0] split_cost;
      logic [COST_BITS-1:0] term;
      logic [63:0]          prod;
      int unsigned          len;
      int unsigned          i;
      int unsigned          j;
      int unsigned          k;
      if (n < 2) return '0;
      for (i = 1; i < n; i++) interval_cost[IDX_BITS'(i)][IDX_BITS'(i)] = '0;
      for (len = 2; len < n; len++) begin
         for (i = 1; i + len - 1 < n; i++) begin
            j    = i + len - 1;
            best = COST_MAX;
            for (k = i; k < j; k++) begin
               prod = 64'(chain_dims[IDX_BITS'(i-1)]) * 64'(chain_dims[IDX_BITS'(k)])
                      * 64'(chain_dims[IDX_BITS'(j)]);
               term = (prod > 64'(COST_MAX)) ? COST_MAX : prod[COST_BITS-1:0];
               split_cost = cost_sum(cost_sum(interval_cost[IDX_BITS'(i)][IDX_BITS'(k)],
                                              interval_cost[IDX_BITS'(k+1)][IDX_BITS'(j)]),
                                     term);
               if (k == i || split_cost < best) best = split_cost;
            end
            interval_cost[IDX_BITS'(i)][IDX_BITS'(j)] = best;
         end
      end
      return interval_cost[IDX_BITS'(1)][IDX_BITS'(n-1)];
   endfunction

   function automatic void record_dimension(input logic [DIM_BITS-1:0] d, input logic l);
      chain_result_type r;
      dims_sent++;
      if (chain_len < MAX_DIMS) begin
         chain_dims[IDX_BITS'(chain_len)] = d;
         chain_len++;
      end else begin
         chain_overflow = 1'b1;
      end
      if (l) begin
         r.min_cost = chain_min_cost(chain_len);
         r.dropped  = chain_overflow;
         pending_costs.push_back(r);
         chain_len      = 0;
         chain_overflow = 1'b0;
         chains_sent++;
      end
   endfunction

   // Sends one dimension; bursts of random length are separated by random gaps.
   task automatic send_dimension(input logic [DIM_BITS-1:0] d, input logic l);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(d);
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      record_dimension(d, l);
   endtask

   function automatic logic [DIM_BITS-1:0] random_dimension();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return DIM_BITS'($urandom);
         4, 5, 6:    return DIM_BITS'($urandom_range(1, 64));
         7:          return '0;
         8:          return '1;
         default:    return DIM_BITS'(1) << $urandom_range(0, DIM_BITS - 1);
      endcase
   endfunction

   task automatic send_random_chain(input int unsigned len);
      int unsigned i;
      for (i = 0; i < len; i++) send_dimension(random_dimension(), i == len - 1);
   endtask

   // Result side: checks every transaction and then drives rsp_tready by the current stall mode.
   initial begin : result_checker
      chain_result_type want;
      int unsigned      stall_step;
      stall_step = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_costs.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual cost %0d dropped %0b",
                        $time, rsp_tdata[COST_BITS-1:0], rsp_tuser);
            end else begin
               want = pending_costs.pop_front();
               results_seen++;
               if (rsp_tuser) dropped_seen++;
               if (rsp_tdata[COST_BITS-1:0] !== want.min_cost) begin
                  errors++;
                  $display("%0t: min_cost mismatch, expected %0d, actual %0d",
                           $time, want.min_cost, rsp_tdata[COST_BITS-1:0]);
               end
               if (rsp_tuser !== want.dropped) begin
                  errors++;
                  $display("%0t: dropped mismatch, expected %0b, actual %0b",
                           $time, want.dropped, rsp_tuser);
               end
            end
         end
         case (stall_mode)
            STALL_NONE: begin
               rsp_tready <= 1'b1;
            end
            STALL_PATTERN: begin
               rsp_tready <= STALL_BITS[4'(stall_step % 13)];
               stall_step++;
            end
            default: begin
               rsp_tready <= ($urandom_range(0, 3) != 0);
            end
         endcase
      end
   end

   task automatic test_short_chains();
      gap_max    = 0;
      stall_mode = STALL_NONE;
      send_dimension('0, 1'b1);
      send_dimension('1, 1'b1);
      send_dimension('0, 1'b0);
      send_dimension('1, 1'b1);
      send_dimension(DIM_BITS'(1), 1'b0);
      send_dimension('1, 1'b1);
   endtask

   task automatic test_known_costs();
      gap_max    = 3;
      stall_mode = STALL_PATTERN;
      send_dimension(DIM_BITS'(10), 1'b0);
      send_dimension(DIM_BITS'(30), 1'b0);
      send_dimension(DIM_BITS'(5), 1'b0);
      send_dimension(DIM_BITS'(60), 1'b1);
      send_dimension(DIM_BITS'(40), 1'b0);
      send_dimension(DIM_BITS'(20), 1'b0);
      send_dimension(DIM_BITS'(30), 1'b0);
      send_dimension(DIM_BITS'(10), 1'b0);
      send_dimension(DIM_BITS'(30), 1'b1);
      // Largest product of three dimensions.
      send_dimension('1, 1'b0);
      send_dimension('1, 1'b0);
      send_dimension('1, 1'b1);
      // Zero dimensions make some splits free.
      send_dimension('0, 1'b0);
      send_dimension(DIM_BITS'(5), 1'b0);
      send_dimension('0, 1'b0);
      send_dimension(DIM_BITS'(7), 1'b1);
   endtask

   task automatic test_random_chains();
      int unsigned seg;
      int unsigned c;
      for (seg = 0; seg < 3; seg++) begin
         case (seg)
            0: begin
               gap_max    = 0;
               stall_mode = STALL_NONE;
            end
            1: begin
               gap_max    = 6;
               stall_mode = STALL_PATTERN;
            end
            default: begin
               gap_max    = 20;
               stall_mode = STALL_RANDOM;
            end
         endcase
         for (c = 0; c < 12; c++) begin
            if ($urandom_range(0, 7) == 0) send_random_chain($urandom_range(13, 20));
            else send_random_chain($urandom_range(1, 12));
         end
      end
   endtask

   task automatic test_long_chains();
      int unsigned i;
      gap_max    = 4;
      stall_mode = STALL_RANDOM;
      send_random_chain(MAX_DIMS - 1);
      send_random_chain(MAX_DIMS);
      // The closing transaction itself is dropped once the store is full.
      send_random_chain(MAX_DIMS + 1);
      send_random_chain(MAX_DIMS + 5);
      // A full chain of the widest dimensions gives the largest cost.
      for (i = 0; i < MAX_DIMS; i++) send_dimension('1, i == MAX_DIMS - 1);
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_short_chains();
      test_known_costs();
      test_random_chains();
      test_long_chains();
      req_tvalid <= 1'b0;
      while (pending_costs.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d dimensions in %0d chains, with and without gaps and stalls.",
               dims_sent, chains_sent);
      $display("Checked %0d results, %0d of them with dropped dimensions.",
               results_seen, dropped_seen);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("Timed out with %0d results outstanding.", pending_costs.size());
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mcmc_pkg.sv
rtl/matrix_chain_min_cost_unit.sv
dv/tb_matrix_chain_min_cost_unit.sv
